// ===== rtl/lme_pkg.sv =====
// Shared types and constants for the LSB message extractor.
// Depends on nothing; every module of the block imports it, the two interfaces do not.
`default_nettype none

package lme_pkg;

  // Default width of the length and checksum header fields.
  localparam int unsigned HEADER_FIELD_BITS_DEFAULT = 32;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned SUM_BITS  = 32;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_SHORT    = 2'd3
  } lme_status_t;

  // One accepted cover beat, reduced to what the extractor uses.
  typedef struct packed {
    logic data_bit;
    logic image_end;
  } lme_beat_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] message_byte;
    logic                 byte_present;
    logic                 message_last;
    lme_status_t          status;
  } lme_result_t;

endpackage

`default_nettype wire

// ===== rtl/lme_in_if.sv =====
// Valid/ready channel that carries cover image bytes into the extractor.
// Standalone; no package dependency.
`default_nettype none

interface lme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic       image_end;

  modport source (output valid, output cover_byte, output image_end, input ready);
  modport sink   (input valid, input cover_byte, input image_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/lme_out_if.sv =====
// Valid/ready channel that carries extracted message results.
// Standalone; no package dependency.
`default_nettype none

interface lme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       message_last;
  logic [1:0] status;

  modport source (output valid, output message_byte, output byte_present,
                  output message_last, output status, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input message_last, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lme_in_stage.sv =====
// Input register of the extractor: captures one cover beat per cycle while its held beat moves on.
// Depends on lme_pkg and lme_in_if.
`default_nettype none

module lme_in_stage
  import lme_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  lme_in_if.sink     pixels,
  input  wire logic  take,
  output lme_beat_t  beat,
  output logic       full
);

  // The register can refill in the same cycle that its beat moves on.
  assign pixels.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (pixels.ready) begin
      full <= pixels.valid;
    end
    if (pixels.valid && pixels.ready) begin
      beat.data_bit  <= pixels.cover_byte[0];
      beat.image_end <= pixels.image_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lme_extract_core.sv =====
// Extraction state machine: gathers header and message bits and forms results.
// Depends on lme_pkg.
`default_nettype none

module lme_extract_core
  import lme_pkg::*;
#(
  parameter int unsigned HEADER_FIELD_BITS = HEADER_FIELD_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire lme_beat_t   beat,
  output lme_result_t      res,
  output logic             res_valid
);

  localparam int unsigned POS_W = $clog2(HEADER_FIELD_BITS);
  localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_FIELD_BITS - 1);
  localparam logic [POS_W-1:0] BYTE_LAST = POS_W'(BYTE_BITS - 1);

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_SUM    = 2'd1,
    PH_MSG    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t                       phase, phase_next;
  logic [POS_W-1:0]             pos, pos_next;
  logic [HEADER_FIELD_BITS-1:0] gather, gather_next, gather_set;
  logic [HEADER_FIELD_BITS-1:0] remaining, remaining_next;
  logic [HEADER_FIELD_BITS-1:0] expected, expected_next;
  logic [SUM_BITS-1:0]          running, running_next, sum_add;

  assign gather_set = gather | (HEADER_FIELD_BITS'(beat.data_bit) << pos);
  assign sum_add    = running + SUM_BITS'(gather_set[BYTE_BITS-1:0]);

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    gather_next    = gather;
    remaining_next = remaining;
    expected_next  = expected;
    running_next   = running;
    res_valid      = 1'b0;
    res.message_byte = '0;
    res.byte_present = 1'b0;
    res.message_last = 1'b0;
    res.status       = ST_BUSY;

    unique case (phase)
      PH_LENGTH: begin
        if (pos == HDR_LAST) begin
          remaining_next = gather_set;
          gather_next    = '0;
          pos_next       = '0;
          phase_next     = PH_SUM;
        end else begin
          gather_next = gather_set;
          pos_next    = pos + POS_W'(1);
        end
      end
      PH_SUM: begin
        if (pos == HDR_LAST) begin
          expected_next = gather_set;
          gather_next   = '0;
          pos_next      = '0;
          if (remaining == '0) begin
            res_valid        = 1'b1;
            res.message_last = 1'b1;
            res.status = (running == SUM_BITS'(gather_set)) ? ST_MATCH : ST_MISMATCH;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_MSG;
          end
        end else begin
          gather_next = gather_set;
          pos_next    = pos + POS_W'(1);
        end
      end
      PH_MSG: begin
        if (pos == BYTE_LAST) begin
          gather_next      = '0;
          pos_next         = '0;
          running_next     = sum_add;
          remaining_next   = remaining - HEADER_FIELD_BITS'(1);
          res_valid        = 1'b1;
          res.message_byte = gather_set[BYTE_BITS-1:0];
          res.byte_present = 1'b1;
          if (remaining == HEADER_FIELD_BITS'(1)) begin
            res.message_last = 1'b1;
            res.status = (sum_add == SUM_BITS'(expected)) ? ST_MATCH : ST_MISMATCH;
            phase_next = PH_DONE;
          end
        end else begin
          gather_next = gather_set;
          pos_next    = pos + POS_W'(1);
        end
      end
      PH_DONE: begin
        // Remaining cover bytes of the image carry nothing.
      end
      default: begin
      end
    endcase

    // Image ended with the message unfinished: report truncation, keeping
    // any byte that this same beat completed.
    if (beat.image_end && (phase_next != PH_DONE)) begin
      res_valid        = 1'b1;
      res.message_last = 1'b1;
      res.status       = ST_SHORT;
    end

    // The last beat of an image rearms the block for the next one.
    if (beat.image_end) begin
      phase_next     = PH_LENGTH;
      pos_next       = '0;
      gather_next    = '0;
      remaining_next = '0;
      expected_next  = '0;
      running_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LENGTH;
      pos       <= '0;
      gather    <= '0;
      remaining <= '0;
      expected  <= '0;
      running   <= '0;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      gather    <= gather_next;
      remaining <= remaining_next;
      expected  <= expected_next;
      running   <= running_next;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> !res_valid)
    else $error("result formed after the message was complete");

  a_last_has_verdict: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.message_last) |-> (res.status != ST_BUSY))
    else $error("final result carries an in-progress status");

  a_mid_has_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.message_last) |-> (res.byte_present && res.status == ST_BUSY))
    else $error("intermediate result without a message byte");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (step && beat.image_end) |=> (phase == PH_LENGTH && pos == '0 && running == '0))
    else $error("end of image did not rearm the extractor");

endmodule

`default_nettype wire

// ===== rtl/lme_out_stage.sv =====
// Output register of the extractor: holds one result until it is taken.
// Depends on lme_pkg and lme_out_if.
`default_nettype none

module lme_out_stage
  import lme_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire lme_result_t res,
  output logic        room,
  lme_out_if.source   message
);

  logic        valid;
  lme_result_t held;

  assign room = !valid || message.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
    if (load && room) begin
      held <= res;
    end
  end

  assign message.valid        = valid;
  assign message.message_byte = held.message_byte;
  assign message.byte_present = held.byte_present;
  assign message.message_last = held.message_last;
  assign message.status       = held.status;

endmodule

`default_nettype wire

// ===== rtl/lsb_message_extractor.sv =====
// LSB message extractor: input register, extraction state machine, output register.
// Path: a beat accepted into the input register goes through the core when it is taken,
// and its result is registered in the output register; a result that cannot be written stalls the beat.
// Throughput: one cover beat per cycle, sustained while results are taken;
// beats that give no result keep flowing even while a result waits.
// Reset (rst, synchronous): empties both registers and rearms to the length header.
// Depends on lme_pkg, lme_in_if, lme_out_if and the three lme_ submodules.
`default_nettype none

module lsb_message_extractor
  import lme_pkg::*;
#(
  parameter int unsigned HEADER_FIELD_BITS = HEADER_FIELD_BITS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  lme_in_if.sink    pixels,
  lme_out_if.source message
);

  // Beat held in the input register, waiting to go through the core.
  lme_beat_t   beat;
  logic        in_full;

  // Result the core forms from the held beat and its current state.
  lme_result_t res;
  logic        res_valid;

  logic        out_room;
  logic        take;

  // The held beat goes through the core when its result, if it has one,
  // can be written to the output register in the same edge. A beat that
  // gives no result never waits on the output side.
  assign take = in_full && (!res_valid || out_room);

  lme_in_stage u_in (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .take   (take),
    .beat   (beat),
    .full   (in_full)
  );

  lme_extract_core #(
    .HEADER_FIELD_BITS (HEADER_FIELD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .beat      (beat),
    .res       (res),
    .res_valid (res_valid)
  );

  lme_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && res_valid),
    .res     (res),
    .room    (out_room),
    .message (message)
  );

endmodule

`default_nettype wire

// ===== dv/lme_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the LSB message extractor testbench: bit-level extraction predictor
// and the in-order store of expected message results. Depends on lme_pkg.

package lme_scoreboard_pkg;
  import lme_pkg::*;

  class lme_scoreboard;
    typedef enum logic [1:0] {
      GET_LENGTH,
      GET_CHECKSUM,
      GET_BODY,
      SKIP_REST
    } parse_phase_t;

    int unsigned  field_bits;
    parse_phase_t phase;
    logic [4:0]   bit_pos;
    logic [31:0]  gather;
    logic [31:0]  bytes_left;
    logic [31:0]  want_sum;
    logic [31:0]  byte_sum;
    lme_result_t  expected_q[$];

    int unsigned  errors;
    int unsigned  checked;
    int unsigned  byte_count;
    int unsigned  match_count;
    int unsigned  mismatch_count;
    int unsigned  short_count;

    function new(int unsigned header_bits);
      field_bits     = header_bits;
      errors         = 0;
      checked        = 0;
      byte_count     = 0;
      match_count    = 0;
      mismatch_count = 0;
      short_count    = 0;
      rearm();
    endfunction

    function void rearm();
      phase      = GET_LENGTH;
      bit_pos    = '0;
      gather     = '0;
      bytes_left = '0;
      want_sum   = '0;
      byte_sum   = '0;
    endfunction

    // Places one payload bit, LSB first; returns 1 once a field of width bits is full.
    function bit take_bit(logic payload, int unsigned width);
      gather = gather | (32'(payload) << bit_pos);
      if (int'(bit_pos) + 1 >= int'(width)) begin
        bit_pos = '0;
        return 1'b1;
      end
      bit_pos = bit_pos + 5'd1;
      return 1'b0;
    endfunction

    function lme_status_t sum_status();
      return (byte_sum == want_sum) ? ST_MATCH : ST_MISMATCH;
    endfunction

    function void note_beat(logic [7:0] cover_byte, logic image_end);
      lme_result_t res;
      bit          have;
      bit          got_byte;
      logic [7:0]  data;
      have     = 1'b0;
      got_byte = 1'b0;
      data     = '0;
      res      = '0;
      if (phase == SKIP_REST) begin
        if (image_end) rearm();
        return;
      end
      case (phase)
        GET_LENGTH: begin
          if (take_bit(cover_byte[0], field_bits)) begin
            bytes_left = gather;
            gather     = '0;
            phase      = GET_CHECKSUM;
          end
        end
        GET_CHECKSUM: begin
          if (take_bit(cover_byte[0], field_bits)) begin
            want_sum = gather;
            gather   = '0;
            if (bytes_left == 0) begin
              res   = '{message_byte: 8'h00, byte_present: 1'b0, message_last: 1'b1,
                        status: sum_status()};
              have  = 1'b1;
              phase = SKIP_REST;
            end else begin
              phase = GET_BODY;
            end
          end
        end
        default: begin
          if (take_bit(cover_byte[0], BYTE_BITS)) begin
            data       = gather[7:0];
            gather     = '0;
            got_byte   = 1'b1;
            byte_sum   = byte_sum + 32'(data);
            bytes_left = bytes_left - 32'd1;
            have       = 1'b1;
            if (bytes_left == 0) begin
              res   = '{message_byte: data, byte_present: 1'b1, message_last: 1'b1,
                        status: sum_status()};
              phase = SKIP_REST;
            end else begin
              res = '{message_byte: data, byte_present: 1'b1, message_last: 1'b0,
                      status: ST_BUSY};
            end
          end
        end
      endcase
      if (image_end) begin
        if (phase != SKIP_REST) begin
          if (got_byte) begin
            res = '{message_byte: data, byte_present: 1'b1, message_last: 1'b1,
                    status: ST_SHORT};
          end else begin
            res = '{message_byte: 8'h00, byte_present: 1'b0, message_last: 1'b1,
                    status: ST_SHORT};
          end
          have = 1'b1;
        end
        rearm();
      end
      if (have) expected_q.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("tb_top: result %0d: %s is %0h, expected %0h", checked, what, got, want);
    endtask

    task check_result(lme_result_t got);
      lme_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report("result with none outstanding, byte", 32'(got.message_byte), 32'h0);
        return;
      end
      want = expected_q.pop_front();
      if (got.message_byte !== want.message_byte)
        report("message_byte", 32'(got.message_byte), 32'(want.message_byte));
      if (got.byte_present !== want.byte_present)
        report("byte_present", 32'(got.byte_present), 32'(want.byte_present));
      if (got.message_last !== want.message_last)
        report("message_last", 32'(got.message_last), 32'(want.message_last));
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (want.byte_present) byte_count++;
      case (want.status)
        ST_MATCH:    match_count++;
        ST_MISMATCH: mismatch_count++;
        ST_SHORT:    short_count++;
        default:     ;
      endcase
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level testbench for lsb_message_extractor: builds cover images bit by bit,
// drives them through the pixels channel and checks every message result.
// Depends on lme_pkg, lme_in_if, lme_out_if and lme_scoreboard_pkg.

module tb_top;
  import lme_pkg::*;
  import lme_scoreboard_pkg::*;

  // The block runs with its default header width; the stimulus builds headers to match.
  localparam int unsigned HDR_BITS     = HEADER_FIELD_BITS_DEFAULT;
  localparam int unsigned RANDOM_BEATS = 1150;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lme_in_if  pixels();
  lme_out_if message();

  lsb_message_extractor #(
    .HEADER_FIELD_BITS(HDR_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .message(message)
  );

  lme_scoreboard sb;

  // Payload bits of the image under construction, in transmit order, and the message
  // bytes that go into it.
  bit          image_bits[$];
  logic [7:0]  body_bytes[$];

  int unsigned beats_sent    = 0;
  int unsigned images_sent   = 0;
  bit          sender_eager  = 1'b0;
  bit          taker_eager   = 1'b0;
  bit          long_hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a legal run finishes well before this timeout, so it only fires when the
  // block hangs or loses results.
  initial begin
    #2_000_000;
    $display("tb_top: timeout with %0d results outstanding", sb.pending());
    $display("tb_top: FAIL");
    $finish;
  end

  // Sends one cover beat. Only bit 0 carries payload; the upper bits are random so
  // that every bit of cover_byte toggles and the block has to ignore them.
  task automatic send_beat(input bit payload, input bit last_beat);
    int unsigned gap;
    logic [6:0]  upper;
    gap   = sender_eager ? 0 : $urandom_range(0, 3);
    upper = 7'($urandom);
    if (gap > 0) begin
      @(negedge clk) pixels.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pixels.valid      <= 1'b1;
    pixels.cover_byte <= {upper, payload};
    pixels.image_end  <= last_beat;
    do @(posedge clk); while (!(pixels.valid && pixels.ready));
    sb.note_beat(pixels.cover_byte, pixels.image_end);
    beats_sent++;
  endtask

  task automatic put_field(input logic [31:0] value, input int unsigned width);
    for (int i = 0; i < int'(width); i++) image_bits.push_back(value[i]);
  endtask

  function automatic logic [31:0] body_sum();
    logic [31:0] acc;
    acc = '0;
    foreach (body_bytes[i]) acc = acc + 32'(body_bytes[i]);
    return acc;
  endfunction

  // Lays out an embedded message: length header, checksum header, the bytes in
  // body_bytes, then trailing padding that the block must skip.
  task automatic load_image(input logic [31:0] length, input logic [31:0] checksum,
                            input int unsigned trailer);
    put_field(length, HDR_BITS);
    put_field(checksum, HDR_BITS);
    foreach (body_bytes[i]) put_field(32'(body_bytes[i]), 8);
    repeat (trailer) image_bits.push_back(1'($urandom));
  endtask

  // Sends the image, raising image_end on its last beat, or on beat cut when the
  // image is to be truncated there.
  task automatic send_image(input int cut);
    int last_idx;
    last_idx = (cut >= 0 && cut < image_bits.size()) ? cut : image_bits.size() - 1;
    for (int i = 0; i <= last_idx; i++) send_beat(image_bits[i], i == last_idx);
    image_bits.delete();
    body_bytes.delete();
    images_sent++;
  endtask

  // Holds the sender back until the block has delivered every result owed so far.
  // The offer is withdrawn first so that the last beat is not taken a second time.
  task automatic wait_for_results();
    @(negedge clk) pixels.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: takes each result after a random stall, none in eager stretches, and holds
  // off for LONG_HOLD once on request so that the output and input registers both fill up.
  initial begin
    int unsigned held_cycles;
    lme_result_t got;
    message.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        @(negedge clk) message.ready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < LONG_HOLD) begin
          @(negedge clk);
          held_cycles++;
        end
        long_hold_req = 1'b0;
      end else begin
        int unsigned stall;
        stall = taker_eager ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          @(negedge clk) message.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
      @(negedge clk) message.ready <= 1'b1;
      do @(posedge clk); while (!(message.valid && message.ready));
      got.message_byte = message.message_byte;
      got.byte_present = message.byte_present;
      got.message_last = message.message_last;
      got.status       = lme_status_t'(message.status);
      sb.check_result(got);
      if (sb.checked % 40 == 0) taker_eager = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int          kind;
    int          cut;
    int unsigned n_bytes;
    int unsigned trailer;
    int unsigned random_start;
    int unsigned random_images;
    logic [31:0] chk;

    pixels.valid      = 1'b0;
    pixels.cover_byte = 8'h00;
    pixels.image_end  = 1'b0;
    sb = new(HDR_BITS);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // ---------------------------------------------------------------------------
    // Directed cases.
    // ---------------------------------------------------------------------------

    // Image that ends on its very first beat: truncation with no byte.
    image_bits.push_back(1'b1);
    send_image(-1);

    // Empty message whose checksum is zero matches; the padding after it is skipped.
    load_image(32'd0, 32'd0, 3);
    send_image(-1);

    // Empty message with an all-ones checksum mismatches, and the image ends on the
    // very beat that completes the checksum header, so no truncation follows.
    load_image(32'd0, 32'hFFFF_FFFF, 0);
    send_image(-1);

    // Byte extremes with a correct checksum, followed by padding.
    body_bytes = '{8'h00, 8'hFF, 8'hA5};
    load_image(32'd3, body_sum(), 5);
    send_image(-1);

    // Wrong checksum; the image ends on the last payload bit.
    body_bytes = '{8'hFF, 8'hFF};
    load_image(32'd2, body_sum() + 32'd1, 0);
    send_image(-1);

    // Image ends in the middle of the length header.
    load_image(32'hFFFF_FFFF, 32'd0, 0);
    send_image(10);

    // Image ends on the beat that completes a message byte: the truncation result
    // carries that byte.
    body_bytes = '{8'h5A, 8'hC3};
    load_image(32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_image(2 * HDR_BITS + 15);

    // Image ends on the beat that completes the checksum of a non-empty message.
    body_bytes = '{8'h01, 8'h02, 8'h03, 8'h04};
    load_image(32'd4, body_sum(), 0);
    send_image(2 * HDR_BITS - 1);

    // Single byte, matching, with a long stretch of ignored padding.
    body_bytes = '{8'hFF};
    load_image(32'd1, 32'h0000_00FF, 20);
    send_image(-1);

    // Single byte whose checksum differs only in the top bit.
    body_bytes = '{8'h80};
    load_image(32'd1, 32'h8000_0080, 2);
    send_image(-1);

    // The sender pauses here until the block has caught up completely.
    wait_for_results();

    // ---------------------------------------------------------------------------
    // Random images: mostly well-formed messages with random content, some cut
    // short, some pure noise.
    // ---------------------------------------------------------------------------
    random_start  = beats_sent;
    random_images = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      kind         = $urandom_range(0, 9);
      sender_eager = ($urandom_range(0, 3) == 0);
      cut          = -1;
      n_bytes      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n_bytes) body_bytes.push_back(8'($urandom));
      chk = body_sum();
      if (kind < 7) begin
        if ($urandom_range(0, 3) == 0) chk = chk ^ (32'h1 << $urandom_range(0, 31));
        trailer = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        load_image(n_bytes, chk, trailer);
      end else if (kind < 9) begin
        load_image(n_bytes, chk, 0);
        // For a non-empty message, half of the cuts land exactly where a message byte completes.
        if (n_bytes > 0 && $urandom_range(0, 1) == 1)
          cut = 2 * HDR_BITS + 8 * $urandom_range(1, n_bytes) - 1;
        else
          cut = $urandom_range(0, image_bits.size() - 1);
      end else begin
        body_bytes.delete();
        repeat ($urandom_range(1, 120)) image_bits.push_back(1'($urandom));
      end
      send_image(cut);
      random_images++;
      if (random_images == 6) long_hold_req = 1'b1;
      if (random_images == 12) wait_for_results();
    end

    @(negedge clk) pixels.valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d cover beats in %0d images; %0d results checked, %0d with a byte",
             beats_sent, images_sent, sb.checked, sb.byte_count);
    $display("tb_top: messages closed by checksum match %0d, mismatch %0d, early end %0d",
             sb.match_count, sb.mismatch_count, sb.short_count);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
